// ===== src/tsp_pkg.sv =====
package tsp_pkg;

  // Transport stream framing.
  localparam int PacketBytes = 188;
  localparam int PosW        = $clog2(PacketBytes);
  localparam int RamDepth    = 2 * PacketBytes;
  localparam int RamAw       = $clog2(RamDepth);

  // Default counter width; the top level may narrow it.
  localparam int CountBits   = 32;
  localparam int CountOutW   = 32;
  localparam int MaxRecords  = 40;
  localparam int Percent     = 100;
  localparam int AdaptMax    = 183;

  localparam logic [7:0]  SyncByte = 8'h47;
  localparam logic [12:0] NullPid  = 13'h1FFF;
  localparam logic [31:0] CrcPoly  = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;

  localparam logic [7:0] TidPat = 8'h00;
  localparam logic [7:0] TidPmt = 8'h02;
  localparam logic [7:0] TidSdt = 8'h42;

  typedef enum logic [1:0] {
    KindStatus,
    KindPmt,
    KindSdt,
    KindStats
  } kind_e;

  typedef enum logic [3:0] {
    StPmt,
    StPat,
    StSdt,
    StOther,
    StNull,
    StNoSync,
    StBadAdapt,
    StPtrFar,
    StBadLen,
    StCrcFail
  } status_e;

  typedef enum logic [4:0] {
    BkIdle,
    BkH0,
    BkH1,
    BkH2,
    BkH3,
    BkH4,
    BkPtr,
    BkT0,
    BkT1,
    BkT2,
    BkCrc,
    BkChk,
    BkP10,
    BkP11,
    BkPw,
    BkE0,
    BkE1,
    BkE2,
    BkE3,
    BkE4,
    BkSt,
    BkS3,
    BkS4,
    BkS5,
    BkS6,
    BkStats,
    BkDiv,
    BkStatsOut,
    BkFin
  } back_state_e;

  // Head of the command queue, front to back.
  typedef struct packed {
    logic valid;
    logic stats;
    logic bank;
  } cmd_t;

  // Packet buffer release, back to front.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [12:0] packet_pid;
    logic [5:0]  entry_index;
    logic [7:0]  stream_type;
    logic [12:0] stream_pid;
    logic [7:0]  provider_offset;
    logic [7:0]  provider_length;
    logic [7:0]  service_name_length;
    logic [CountOutW-1:0] packets_counted;
    logic [6:0]  null_percent;
    logic        last;
  } rec_t;

endpackage

// ===== src/ts_psi_section_parser_core.sv =====
// Throughput: one byte per cycle while a packet buffer is free and the command queue has room;
//   the back end walks each packet byte by byte, through the header, the section and its PMT
//   or SDT loops, and a statistics request runs through the serial percent divider.
// Reset (rst_ni, asynchronous, active low) clears framing, counters, queue and outputs.
module ts_psi_section_parser_core import tsp_pkg::*; #(
  parameter int CountBitsP = tsp_pkg::CountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  status_o,
  output logic [12:0] packet_pid_o,
  output logic [5:0]  entry_index_o,
  output logic [7:0]  stream_type_o,
  output logic [12:0] stream_pid_o,
  output logic [7:0]  provider_offset_o,
  output logic [7:0]  provider_length_o,
  output logic [7:0]  service_name_length_o,
  output logic [31:0] packets_counted_o,
  output logic [6:0]  null_percent_o,
  output logic        last_o
);

  // The front end frames bytes into one of two packet buffers held in a single RAM and
  // queues a command per finished packet or statistics request. The back end walks the
  // buffered packet byte by byte: header, adaptation and pointer fields, the section
  // with its CRC, then the PMT or SDT loops. While it walks one buffer, the front end
  // fills the other one, so packet arrival and table walks overlap.
  logic             wr_en;
  logic [RamAw-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;
  cmd_t             head;
  logic             pop;
  rel_t             rel;
  rec_t             rec;

  tsp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .head_o         (head),
    .pop_i          (pop),
    .rel_i          (rel)
  );

  // Two packet buffers back to back; the read port belongs to the back end.
  tsp_ram #(
    .Width (8),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // The back end keeps one record buffered so that it can mark the final record of a
  // request, and drives the output register directly.
  tsp_back #(
    .CntW (CountBitsP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .rel_o       (rel),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec)
  );

  assign kind_o                = rec.kind;
  assign status_o              = rec.status;
  assign packet_pid_o          = rec.packet_pid;
  assign entry_index_o         = rec.entry_index;
  assign stream_type_o         = rec.stream_type;
  assign stream_pid_o          = rec.stream_pid;
  assign provider_offset_o     = rec.provider_offset;
  assign provider_length_o     = rec.provider_length;
  assign service_name_length_o = rec.service_name_length;
  assign packets_counted_o     = rec.packets_counted;
  assign null_percent_o        = rec.null_percent;
  assign last_o                = rec.last;

endmodule

// ===== src/tsp_ram.sv =====
module tsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 376
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tsp_div.sv =====
module tsp_div import tsp_pkg::*; #(
  parameter int CntW = tsp_pkg::CountBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [CntW-1:0] num_i,
  input  logic [CntW-1:0] den_i,
  output logic            done_o,
  output logic [6:0]      quot_o
);

  localparam int NW = CntW + 7;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [2:0]    step_q, step_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [CntW-1:0] den_q, den_d;
  logic [6:0]    quot_q, quot_d;
  logic [NW-1:0] trial;
  logic          fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign trial = NW'(den_q) << step_q;
  assign fits  = rem_q >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 3'd6;
      rem_d  = NW'(num_i) * NW'(Percent);
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[5:0], fits};
      if (fits) begin
        rem_d = rem_q - trial;
      end
      if (step_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/tsp_front.sv =====
module tsp_front import tsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [7:0]       data_byte_i,
  input  logic             packet_start_i,
  output logic             wr_en_o,
  output logic [RamAw-1:0] wr_addr_o,
  output logic [7:0]       wr_data_o,
  output cmd_t             head_o,
  input  logic             pop_i,
  input  rel_t             rel_i
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;
  logic [1:0]      ent_q [2];
  logic            rd_ptr_q, wr_ptr_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            accept, complete, push;
  logic [PosW-1:0] start_pos;

  assign in_ready_o = (cnt_q != 2'd2) && !busy_q[bank_q];
  assign accept     = in_valid_i && in_ready_o;
  assign start_pos  = packet_start_i ? '0 : pos_q;
  assign wr_en_o    = accept && !operation_i;
  assign wr_addr_o  = bank_q ? RamAw'(start_pos) + RamAw'(PacketBytes) : RamAw'(start_pos);
  assign wr_data_o  = data_byte_i;
  assign complete   = wr_en_o && (start_pos == PosW'(PacketBytes - 1));
  assign push       = accept && (operation_i || complete);

  always_comb begin
    pos_d  = pos_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (accept) begin
      if (operation_i || complete) begin
        pos_d = '0;
      end else begin
        pos_d = start_pos + PosW'(1);
      end
    end
    if (complete) begin
      bank_d         = ~bank_q;
      busy_d[bank_q] = 1'b1;
    end
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
  end

  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      bank_q   <= 1'b0;
      busy_q   <= '0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      pos_q  <= pos_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= {operation_i, bank_q};
    end
  end

  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.stats = ent_q[rd_ptr_q][1];
  assign head_o.bank  = ent_q[rd_ptr_q][0];

endmodule

// ===== src/tsp_back.sv =====
module tsp_back import tsp_pkg::*; #(
  parameter int CntW = tsp_pkg::CountBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             head_i,
  output logic             pop_o,
  output rel_t             rel_o,
  output logic [RamAw-1:0] rd_addr_o,
  input  logic [7:0]       rd_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rec_t             rec_o
);

  localparam int PtrW = 16;
  localparam logic [PtrW-1:0] PktEnd   = PtrW'(PacketBytes);
  localparam logic [PtrW-1:0] PtrLimit = PtrW'(PacketBytes - 3);
  localparam logic [PtrW-1:0] FieldEnd = PtrW'(PacketBytes - 4);

  back_state_e state_q, state_d;

  logic            bank_q, bank_d, stats_q, stats_d;
  logic [PtrW-1:0] ptr_q, ptr_d, po_q, po_d, walk_q, walk_d, es_q, es_d, tpos_q, tpos_d;
  logic            sync_q, sync_d;
  logic [12:0]     pid_q, pid_d, spid_q, spid_d;
  logic [7:0]      tid_q, tid_d, hi_q, hi_d, b_q, b_d;
  logic [11:0]     sl_q, sl_d, cnt_q, cnt_d, pil_q, pil_d, ll_q, ll_d;
  logic [31:0]     crc_q, crc_d, got_q, got_d;
  logic [5:0]      idx_q, idx_d, n_q, n_d;
  rec_t            hold_q, hold_d, out_q, out_d, rec_new;
  logic            hold_v_q, hold_v_d, out_v_q, out_v_d;
  logic [CntW-1:0] total_q, total_d, null_q, null_d;

  logic            oob, can_gen, out_free, gen, stall, fin_go, div_start, div_done;
  logic [7:0]      cur;
  logic [PtrW-1:0] cur16, po_calc, es_calc, t_calc, lpos;
  logic [11:0]     sl_calc;
  logic            afl_bad, po_far, len_bad, crc_ok, pmt_cont, sdt_cont;
  logic [6:0]      div_quot;
  status_e         tab_status;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {b, 24'b0};
    for (int i = 0; i < 8; i++) begin
      x = x[31] ? ((x << 1) ^ CrcPoly) : (x << 1);
    end
    return x;
  endfunction

  // The RAM is read every cycle at the next pointer, so cur is the byte at ptr_q.
  assign oob   = ptr_q >= PktEnd;
  assign cur   = oob ? 8'd0 : rd_data_i;
  assign cur16 = PtrW'(cur);

  assign out_free = !out_v_q || out_ready_i;
  assign can_gen  = !hold_v_q || out_free;

  assign afl_bad  = (cur == 8'd0) || (cur > 8'(AdaptMax));
  assign po_calc  = ptr_q + PtrW'(1) + cur16;
  assign po_far   = po_calc >= PtrLimit;
  assign sl_calc  = {hi_q[3:0], cur};
  assign len_bad  = (sl_calc == 12'd0) || (po_q + PtrW'(sl_calc) + PtrW'(3) > PktEnd);
  assign crc_ok   = got_q == crc_q;
  assign es_calc  = po_q + PtrW'(12) + PtrW'(pil_q) + walk_q;
  assign pmt_cont = (PtrW'(12) + PtrW'(pil_q) + walk_q < PtrW'(sl_q) - PtrW'(1))
                    && (n_q < 6'(MaxRecords));
  assign t_calc   = po_q + tpos_q;
  assign sdt_cont = (tpos_q < PtrW'(sl_q) - PtrW'(1)) && (n_q < 6'(MaxRecords));
  assign lpos     = es_q + PtrW'(9) + cur16;
  assign fin_go   = (state_q == BkFin) && out_free;

  always_comb begin
    case (tid_q)
      TidPmt:  tab_status = StPmt;
      TidPat:  tab_status = StPat;
      TidSdt:  tab_status = StSdt;
      default: tab_status = StOther;
    endcase
  end

  // Record generation for the current state.
  always_comb begin
    gen                 = 1'b0;
    rec_new             = '0;
    rec_new.kind        = KindStatus;
    rec_new.status      = StPmt;
    rec_new.packet_pid  = pid_q;
    unique case (state_q)
      BkH3: begin
        if (!sync_q) begin
          gen            = 1'b1;
          rec_new.status = StNoSync;
        end else if (pid_q == NullPid) begin
          gen            = 1'b1;
          rec_new.status = StNull;
        end
      end
      BkH4: begin
        gen            = afl_bad;
        rec_new.status = StBadAdapt;
      end
      BkPtr: begin
        gen            = po_far;
        rec_new.status = StPtrFar;
      end
      BkT2: begin
        gen            = len_bad;
        rec_new.status = StBadLen;
      end
      BkChk: begin
        gen            = 1'b1;
        rec_new.status = crc_ok ? tab_status : StCrcFail;
      end
      BkE4: begin
        gen                 = 1'b1;
        rec_new.kind        = KindPmt;
        rec_new.status      = StPmt;
        rec_new.entry_index = idx_q;
        rec_new.stream_type = b_q;
        rec_new.stream_pid  = spid_q;
      end
      BkS6: begin
        gen                         = 1'b1;
        rec_new.kind                = KindSdt;
        rec_new.status              = StSdt;
        rec_new.provider_offset     = 8'(es_q + PtrW'(9));
        rec_new.provider_length     = b_q;
        rec_new.service_name_length = cur;
      end
      BkStatsOut: begin
        gen                     = 1'b1;
        rec_new.kind            = KindStats;
        rec_new.packet_pid      = '0;
        rec_new.packets_counted = CountOutW'(total_q);
        rec_new.null_percent    = (total_q == '0) ? 7'd0 : div_quot;
      end
      default: begin
        gen = 1'b0;
      end
    endcase
  end

  assign stall = gen && !can_gen;

  // Next state.
  always_comb begin
    state_d = state_q;
    if (!stall) begin
      unique case (state_q)
        BkIdle: begin
          if (head_i.valid) begin
            state_d = head_i.stats ? BkStats : BkH0;
          end
        end
        BkH0:  state_d = BkH1;
        BkH1:  state_d = BkH2;
        BkH2:  state_d = BkH3;
        BkH3: begin
          if (gen) begin
            state_d = BkFin;
          end else begin
            state_d = cur[5] ? BkH4 : BkPtr;
          end
        end
        BkH4:  state_d = afl_bad ? BkFin : BkPtr;
        BkPtr: state_d = po_far ? BkFin : BkT0;
        BkT0:  state_d = BkT1;
        BkT1:  state_d = BkT2;
        BkT2:  state_d = len_bad ? BkFin : BkCrc;
        BkCrc: begin
          if (cnt_q == sl_q + 12'd2) begin
            state_d = BkChk;
          end
        end
        BkChk: begin
          if (!crc_ok) begin
            state_d = BkFin;
          end else if (tab_status == StPmt) begin
            state_d = BkP10;
          end else if (tab_status == StSdt) begin
            state_d = BkSt;
          end else begin
            state_d = BkFin;
          end
        end
        BkP10: state_d = BkP11;
        BkP11: state_d = BkPw;
        BkPw:  state_d = (pmt_cont && (es_calc < FieldEnd)) ? BkE0 : BkFin;
        BkE0:  state_d = BkE1;
        BkE1:  state_d = BkE2;
        BkE2:  state_d = BkE3;
        BkE3:  state_d = BkE4;
        BkE4:  state_d = BkPw;
        BkSt:  state_d = (sdt_cont && (t_calc < FieldEnd)) ? BkS3 : BkFin;
        BkS3:  state_d = BkS4;
        BkS4:  state_d = BkS5;
        BkS5:  state_d = (lpos >= PktEnd) ? BkFin : BkS6;
        BkS6:  state_d = BkSt;
        BkStats: state_d = BkDiv;
        BkDiv: begin
          if (div_done) begin
            state_d = BkStatsOut;
          end
        end
        BkStatsOut: state_d = BkFin;
        BkFin: begin
          if (out_free) begin
            state_d = BkIdle;
          end
        end
        default: state_d = BkIdle;
      endcase
    end
  end

  // Datapath and record buffering.
  always_comb begin
    bank_d   = bank_q;
    stats_d  = stats_q;
    ptr_d    = ptr_q;
    po_d     = po_q;
    walk_d   = walk_q;
    es_d     = es_q;
    tpos_d   = tpos_q;
    sync_d   = sync_q;
    pid_d    = pid_q;
    spid_d   = spid_q;
    tid_d    = tid_q;
    hi_d     = hi_q;
    b_d      = b_q;
    sl_d     = sl_q;
    cnt_d    = cnt_q;
    pil_d    = pil_q;
    ll_d     = ll_q;
    crc_d    = crc_q;
    got_d    = got_q;
    idx_d    = idx_q;
    n_d      = n_q;
    total_d  = total_q;
    null_d   = null_q;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !out_ready_i;

    if (!stall) begin
      unique case (state_q)
        BkIdle: begin
          if (head_i.valid) begin
            bank_d  = head_i.bank;
            stats_d = head_i.stats;
            ptr_d   = '0;
            n_d     = '0;
          end
        end
        BkH0: begin
          sync_d = cur == SyncByte;
          ptr_d  = PtrW'(1);
        end
        BkH1: begin
          pid_d[12:8] = cur[4:0];
          ptr_d       = PtrW'(2);
        end
        BkH2: begin
          pid_d[7:0] = cur;
          ptr_d      = PtrW'(3);
        end
        BkH3: begin
          if (sync_q) begin
            if (total_q != '1) begin
              total_d = total_q + CntW'(1);
            end
            if ((pid_q == NullPid) && (null_q != '1)) begin
              null_d = null_q + CntW'(1);
            end
          end
          ptr_d = PtrW'(4);
        end
        BkH4:  ptr_d = PtrW'(4) + cur16;
        BkPtr: begin
          po_d  = po_calc;
          ptr_d = po_calc;
        end
        BkT0: begin
          tid_d = cur;
          ptr_d = po_q + PtrW'(1);
        end
        BkT1: begin
          hi_d  = cur;
          ptr_d = po_q + PtrW'(2);
        end
        BkT2: begin
          sl_d  = sl_calc;
          crc_d = CrcInit;
          cnt_d = '0;
          ptr_d = po_q;
        end
        BkCrc: begin
          if (cnt_q < sl_q - 12'd1) begin
            crc_d = crc_byte(crc_q, cur);
          end else begin
            got_d = {got_q[23:0], cur};
          end
          if (cnt_q != sl_q + 12'd2) begin
            ptr_d = ptr_q + PtrW'(1);
            cnt_d = cnt_q + 12'd1;
          end
        end
        BkChk: begin
          ptr_d  = po_q + PtrW'(10);
          tpos_d = PtrW'(11);
        end
        BkP10: begin
          hi_d  = cur;
          ptr_d = po_q + PtrW'(11);
        end
        BkP11: begin
          pil_d  = {hi_q[3:0], cur};
          walk_d = '0;
          idx_d  = '0;
        end
        BkPw: begin
          es_d  = es_calc;
          ptr_d = es_calc;
        end
        BkE0: begin
          b_d   = cur;
          ptr_d = es_q + PtrW'(1);
        end
        BkE1: begin
          hi_d  = cur;
          ptr_d = es_q + PtrW'(2);
        end
        BkE2: begin
          spid_d = {hi_q[4:0], cur};
          ptr_d  = es_q + PtrW'(3);
        end
        BkE3: begin
          hi_d  = cur;
          ptr_d = es_q + PtrW'(4);
        end
        BkE4: begin
          walk_d = walk_q + PtrW'(5) + PtrW'({hi_q[3:0], cur});
          idx_d  = idx_q + 6'd1;
        end
        BkSt: begin
          es_d  = t_calc;
          ptr_d = t_calc + PtrW'(3);
        end
        BkS3: begin
          hi_d  = cur;
          ptr_d = es_q + PtrW'(4);
        end
        BkS4: begin
          ll_d  = {hi_q[3:0], cur};
          ptr_d = es_q + PtrW'(8);
        end
        BkS5: begin
          b_d   = cur;
          ptr_d = lpos;
        end
        BkS6: begin
          tpos_d = tpos_q + PtrW'(5) + PtrW'(ll_q);
        end
        BkStatsOut: begin
          total_d = '0;
          null_d  = '0;
        end
        default: begin
          ptr_d = ptr_q;
        end
      endcase

      // A new record pushes the buffered one out; the last is marked at the end.
      if (gen) begin
        if (hold_v_q) begin
          out_d      = hold_q;
          out_d.last = 1'b0;
          out_v_d    = 1'b1;
        end
        hold_d   = rec_new;
        hold_v_d = 1'b1;
        n_d      = n_q + 6'd1;
      end
      if (fin_go) begin
        out_d      = hold_q;
        out_d.last = 1'b1;
        out_v_d    = 1'b1;
        hold_v_d   = 1'b0;
      end
    end
  end

  assign rd_addr_o = (ptr_d >= PktEnd) ? '0 :
                     bank_d ? RamAw'(ptr_d[PosW-1:0]) + RamAw'(PacketBytes)
                            : RamAw'(ptr_d[PosW-1:0]);

  assign pop_o      = (state_q == BkIdle) && head_i.valid;
  assign rel_o.valid = fin_go && !stats_q;
  assign rel_o.bank  = bank_q;
  assign div_start  = state_q == BkStats;

  tsp_div #(
    .CntW (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (null_q),
    .den_i   (total_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      total_q  <= '0;
      null_q   <= '0;
      n_q      <= '0;
      bank_q   <= 1'b0;
      stats_q  <= 1'b0;
      ptr_q    <= '0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      total_q  <= total_d;
      null_q   <= null_d;
      n_q      <= n_d;
      bank_q   <= bank_d;
      stats_q  <= stats_d;
      ptr_q    <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    po_q   <= po_d;
    walk_q <= walk_d;
    es_q   <= es_d;
    tpos_q <= tpos_d;
    sync_q <= sync_d;
    pid_q  <= pid_d;
    spid_q <= spid_d;
    tid_q  <= tid_d;
    hi_q   <= hi_d;
    b_q    <= b_d;
    sl_q   <= sl_d;
    cnt_q  <= cnt_d;
    pil_q  <= pil_d;
    ll_q   <= ll_d;
    crc_q  <= crc_d;
    got_q  <= got_d;
    idx_q  <= idx_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign rec_o       = out_q;

  a_hold_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkIdle) |-> !hold_v_q)
    else $error("record buffer not drained at idle");

  a_record_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 6'(MaxRecords))
    else $error("more records than allowed for one request");

  a_null_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    null_q <= total_q)
    else $error("null count exceeds packet count");

  a_release_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_o.valid |-> (state_q == BkFin) && !stats_q && out_free)
    else $error("buffer released outside packet completion");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tsp_pkg::*;

  // Generous cycle budget for a correct run.
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHoldCycles = 3000;

  // Shapes of generated packets.
  typedef enum int {
    FlPmt, FlPat, FlSdt, FlOther, FlNull, FlNoSync,
    FlBadAdapt, FlPtrFar, FlBadLen, FlCrcFail, FlNoise
  } flavor_e;

  // Scoreboard: mirrors the parser and holds the records it should produce.
  class section_scoreboard;
    logic [7:0]  pkt_img[PacketBytes];
    int unsigned fill_pos;
    logic [31:0] synced_count;
    logic [31:0] null_count;
    rec_t        batch[$];
    rec_t        expected_q[$];
    int unsigned errors;

    function new();
      fill_pos = 0;
      synced_count = '0;
      null_count = '0;
      errors = 0;
    endfunction

    function int unsigned byte_at(int unsigned p);
      return (p < PacketBytes) ? int'(pkt_img[p]) : 0;
    endfunction

    // MPEG-2 CRC-32, MSB first, no final inversion.
    function logic [31:0] crc_of(int unsigned s, int unsigned n);
      logic [31:0] crc;
      crc = CrcInit;
      for (int unsigned i = 0; i < n; i++) begin
        crc ^= 32'(byte_at(s + i)) << 24;
        for (int b = 0; b < 8; b++) begin
          crc = crc[31] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
        end
      end
      return crc;
    endfunction

    function void add_rec(rec_t r);
      if (batch.size() < MaxRecords) batch.push_back(r);
    endfunction

    function void parse_packet();
      rec_t v;
      int unsigned pid, off, afl, po, sl, got, pil, walk, idx, es, tpos, t, loop_len;
      int unsigned d, pnl, lpos;
      v = '0;
      pid = ((byte_at(1) & 'h1F) << 8) | byte_at(2);
      v.packet_pid = 13'(pid);
      if (byte_at(0) != int'(SyncByte)) begin
        v.status = StNoSync;
        add_rec(v);
        return;
      end
      if (synced_count != '1) synced_count++;
      if (pid == int'(NullPid)) begin
        if (null_count != '1) null_count++;
        v.status = StNull;
        add_rec(v);
        return;
      end
      off = 4;
      if ((byte_at(3) & 'h20) != 0) begin
        afl = byte_at(4);
        if (afl == 0 || afl > AdaptMax) begin
          v.status = StBadAdapt;
          add_rec(v);
          return;
        end
        off += afl;
      end
      po = off + 1 + byte_at(off);
      if (po >= PacketBytes - 3) begin
        v.status = StPtrFar;
        add_rec(v);
        return;
      end
      sl = ((byte_at(po + 1) & 'h0F) << 8) | byte_at(po + 2);
      if (sl < 1 || po + sl + 3 > PacketBytes) begin
        v.status = StBadLen;
        add_rec(v);
        return;
      end
      got = (byte_at(po + sl - 1) << 24) | (byte_at(po + sl) << 16) |
            (byte_at(po + sl + 1) << 8) | byte_at(po + sl + 2);
      if (got != crc_of(po, sl - 1)) begin
        v.status = StCrcFail;
        add_rec(v);
        return;
      end
      case (byte_at(po))
        int'(TidPmt): v.status = StPmt;
        int'(TidPat): v.status = StPat;
        int'(TidSdt): v.status = StSdt;
        default:      v.status = StOther;
      endcase
      add_rec(v);
      if (v.status == StPmt) begin
        // One record per elementary stream, stopping short of the CRC.
        pil = ((byte_at(po + 10) & 'h0F) << 8) | byte_at(po + 11);
        walk = 0;
        idx = 0;
        v.kind = KindPmt;
        while (12 + pil + walk < sl - 1 && batch.size() < MaxRecords) begin
          es = po + 12 + pil + walk;
          if (es + 4 >= PacketBytes) break;
          v.entry_index = 6'(idx);
          v.stream_type = 8'(byte_at(es));
          v.stream_pid = 13'(((byte_at(es + 1) & 'h1F) << 8) | byte_at(es + 2));
          add_rec(v);
          walk += 5 + (((byte_at(es + 3) & 'h0F) << 8) | byte_at(es + 4));
          idx++;
        end
      end else if (v.status == StSdt) begin
        // The first descriptor of each service is taken as a service descriptor.
        tpos = 11;
        v.kind = KindSdt;
        while (tpos < sl - 1 && batch.size() < MaxRecords) begin
          t = po + tpos;
          if (t + 4 >= PacketBytes) break;
          loop_len = ((byte_at(t + 3) & 'h0F) << 8) | byte_at(t + 4);
          d = t + 5;
          pnl = byte_at(d + 3);
          lpos = d + 4 + pnl;
          if (lpos >= PacketBytes) break;
          v.provider_offset = 8'(d + 4);
          v.provider_length = 8'(pnl);
          v.service_name_length = 8'(byte_at(lpos));
          add_rec(v);
          tpos += 5 + loop_len;
        end
      end
    endfunction

    // Notes one accepted request and queues the records it must cause.
    function void note_request(logic op, logic [7:0] data, logic first);
      rec_t v;
      longint unsigned pct;
      batch.delete();
      if (op) begin
        v = '0;
        v.kind = KindStats;
        v.packets_counted = synced_count;
        pct = (synced_count != 0) ?
              (64'(Percent) * 64'(null_count)) / 64'(synced_count) : 0;
        v.null_percent = 7'(pct);
        add_rec(v);
        synced_count = '0;
        null_count = '0;
        fill_pos = 0;
      end else begin
        if (first || fill_pos >= PacketBytes) fill_pos = 0;
        pkt_img[fill_pos] = data;
        fill_pos++;
        if (fill_pos >= PacketBytes) begin
          fill_pos = 0;
          parse_packet();
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_q.push_back(batch[i]);
    endfunction

    function void compare(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_record(rec_t got);
      rec_t e;
      if (expected_q.size() == 0) begin
        $error("record arrived with nothing expected (kind %0d)", got.kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("kind", e.kind, got.kind);
      compare("status", e.status, got.status);
      compare("packet_pid", e.packet_pid, got.packet_pid);
      compare("entry_index", e.entry_index, got.entry_index);
      compare("stream_type", e.stream_type, got.stream_type);
      compare("stream_pid", e.stream_pid, got.stream_pid);
      compare("provider_offset", e.provider_offset, got.provider_offset);
      compare("provider_length", e.provider_length, got.provider_length);
      compare("service_name_length", e.service_name_length, got.service_name_length);
      compare("packets_counted", e.packets_counted, got.packets_counted);
      compare("null_percent", e.null_percent, got.null_percent);
      compare("last", e.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        operation_i;
  logic [7:0]  data_byte_i;
  logic        packet_start_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [3:0]  status_o;
  logic [12:0] packet_pid_o;
  logic [5:0]  entry_index_o;
  logic [7:0]  stream_type_o;
  logic [12:0] stream_pid_o;
  logic [7:0]  provider_offset_o;
  logic [7:0]  provider_length_o;
  logic [7:0]  service_name_length_o;
  logic [31:0] packets_counted_o;
  logic [6:0]  null_percent_o;
  logic        last_o;

  ts_psi_section_parser_core dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .operation_i           (operation_i),
    .data_byte_i           (data_byte_i),
    .packet_start_i        (packet_start_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .kind_o                (kind_o),
    .status_o              (status_o),
    .packet_pid_o          (packet_pid_o),
    .entry_index_o         (entry_index_o),
    .stream_type_o         (stream_type_o),
    .stream_pid_o          (stream_pid_o),
    .provider_offset_o     (provider_offset_o),
    .provider_length_o     (provider_length_o),
    .service_name_length_o (service_name_length_o),
    .packets_counted_o     (packets_counted_o),
    .null_percent_o        (null_percent_o),
    .last_o                (last_o)
  );

  section_scoreboard sb = new();

  logic [7:0]  pkt_buf[PacketBytes];
  int unsigned cycle_count = 0;
  bit          no_gaps;
  bit          hold_request = 0;
  bit          hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned ready_bias = 100;

  // The clock runs with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result side: check every accepted record, then pick the next ready value.
  // Readiness drifts between eager and sluggish, with short stalls sprinkled
  // in and one long hold-off that lets the block back up into its input.
  always @(posedge clk_i) begin
    rec_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = kind_e'(kind_o);
      got.status = status_e'(status_o);
      got.packet_pid = packet_pid_o;
      got.entry_index = entry_index_o;
      got.stream_type = stream_type_o;
      got.stream_pid = stream_pid_o;
      got.provider_offset = provider_offset_o;
      got.provider_length = provider_length_o;
      got.service_name_length = service_name_length_o;
      got.packets_counted = packets_counted_o;
      got.null_percent = null_percent_o;
      got.last = last_o;
      sb.check_record(got);
    end
    if (cycle_count % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_bias = 25;
        1: ready_bias = 75;
        default: ready_bias = 100;
      endcase
    end
    if (hold_request && !hold_taken) begin
      hold_taken = 1;
      hold_left = LongHoldCycles;
    end else if (hold_left == 0 && $urandom_range(0, 199) == 0) begin
      hold_left = $urandom_range(10, 60);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) < ready_bias);
    end
  end

  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request and holds it until the block takes it.
  task automatic send_request(logic op, logic [7:0] data, logic first);
    int unsigned gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    data_byte_i <= data;
    packet_start_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, data, first);
  endtask

  task automatic send_stats();
    send_request(1'b1, 8'($urandom), 1'($urandom));
  endtask

  // A packet's first byte usually carries packet_start, but position zero
  // also opens a packet on its own, so sometimes it is left low.
  task automatic send_packet(bit force_start);
    for (int i = 0; i < PacketBytes; i++) begin
      send_request(1'b0, pkt_buf[i],
                   (i == 0) ? (force_start || $urandom_range(0, 3) != 0) : 1'b0);
    end
  endtask

  // A fragment that the next packet's start flag, where it is set, throws away.
  task automatic send_fragment();
    int unsigned n;
    n = $urandom_range(1, PacketBytes - 1);
    for (int unsigned i = 0; i < n; i++) begin
      send_request(1'b0, 8'($urandom), (i == 0));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic put(int unsigned idx, int unsigned val);
    if (idx < PacketBytes) pkt_buf[idx] = 8'(val);
  endtask

  // Builds a packet of the given flavor into pkt_buf. Good tables carry a
  // correct CRC; broken flavors are derived from a good one.
  task automatic build_packet(flavor_e fl);
    int unsigned pid, off, afl, ptr, po, sl, slmax, p, el, t, pnl, snl, d, len;
    logic [7:0]  tid;
    logic [31:0] crc;
    bit          adapt;
    for (int i = 0; i < PacketBytes; i++) pkt_buf[i] = 8'($urandom);
    pid = $urandom_range(0, 8190);
    pkt_buf[0] = SyncByte;
    pkt_buf[1] = ($urandom & 8'hE0) | 8'(pid >> 8);
    pkt_buf[2] = 8'(pid);
    adapt = ($urandom_range(0, 3) == 0);
    pkt_buf[3] = ($urandom & 8'hCF) | (adapt ? 8'h20 : 8'h00) | 8'h10;
    off = 4;
    if (adapt) begin
      // Now and then the largest legal adaptation field, which leaves no room.
      afl = ($urandom_range(0, 15) == 0) ? AdaptMax : $urandom_range(1, 20);
      pkt_buf[4] = 8'(afl);
      off += afl;
    end
    ptr = $urandom_range(0, 4);
    put(off, ptr);
    po = off + 1 + ptr;
    case (fl)
      FlPmt:   tid = TidPmt;
      FlPat:   tid = TidPat;
      FlSdt:   tid = TidSdt;
      default: begin
        tid = 8'($urandom);
        if (tid == TidPmt || tid == TidPat || tid == TidSdt) tid = 8'h70;
      end
    endcase
    if (po + 20 <= PacketBytes - 3) begin
      slmax = PacketBytes - 3 - po;
      sl = ($urandom_range(0, 4) == 0) ? slmax : $urandom_range(16, (slmax < 120) ? slmax : 120);
      pkt_buf[po] = tid;
      pkt_buf[po + 1] = $urandom & 8'hF0;
      pkt_buf[po + 2] = 8'(sl);
      if (fl == FlPmt) begin
        pkt_buf[po + 10] = $urandom & 8'hF0;
        pkt_buf[po + 11] = 8'($urandom_range(0, 3));
        p = po + 12 + pkt_buf[po + 11];
        while (p + 4 < po + sl - 1) begin
          el = $urandom_range(0, 4);
          pkt_buf[p + 3] = $urandom & 8'hF0;
          pkt_buf[p + 4] = 8'(el);
          p += 5 + el;
        end
      end else if (fl == FlSdt) begin
        t = po + 11;
        while (t + 4 < po + sl - 1) begin
          pnl = $urandom_range(0, 4);
          snl = $urandom_range(0, 6);
          pkt_buf[t + 3] = $urandom & 8'hF0;
          pkt_buf[t + 4] = 8'(5 + pnl + snl);
          d = t + 5;
          put(d + 3, pnl);
          put(d + 4 + pnl, snl);
          t += 10 + pnl + snl;
        end
      end
      crc = sb_crc(po, sl - 1);
      pkt_buf[po + sl - 1] = crc[31:24];
      pkt_buf[po + sl]     = crc[23:16];
      pkt_buf[po + sl + 1] = crc[15:8];
      pkt_buf[po + sl + 2] = crc[7:0];
      case (fl)
        FlBadLen: begin
          len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(PacketBytes - 2 - po, 4095);
          pkt_buf[po + 1] = ($urandom & 8'hF0) | 8'(len >> 8);
          pkt_buf[po + 2] = 8'(len);
        end
        FlCrcFail: begin
          p = po + $urandom_range(3, sl + 2);
          pkt_buf[p] = pkt_buf[p] ^ (8'h01 << $urandom_range(0, 7));
        end
        default: ;
      endcase
    end
    case (fl)
      FlNull: begin
        pkt_buf[1] = pkt_buf[1] | 8'h1F;
        pkt_buf[2] = 8'hFF;
      end
      FlNoSync: begin
        pkt_buf[0] = 8'($urandom);
        if (pkt_buf[0] == SyncByte) pkt_buf[0] = 8'hB8;
      end
      FlBadAdapt: begin
        pkt_buf[3] = pkt_buf[3] | 8'h20;
        pkt_buf[4] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(AdaptMax + 1, 255));
      end
      FlPtrFar: begin
        pkt_buf[3] = pkt_buf[3] & 8'hDF;
        pkt_buf[4] = 8'($urandom_range(PacketBytes - 8, 255));
      end
      FlNoise: begin
        if ($urandom_range(0, 1) == 0) pkt_buf[0] = 8'($urandom);
      end
      default: ;
    endcase
  endtask

  // CRC for the generator, kept apart from the scoreboard's mirror image.
  function automatic logic [31:0] sb_crc(int unsigned s, int unsigned n);
    logic [31:0] crc;
    crc = CrcInit;
    for (int unsigned i = 0; i < n; i++) begin
      crc ^= {pkt_buf[s + i], 24'h0};
      for (int b = 0; b < 8; b++) crc = crc[31] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
    end
    return crc;
  endfunction

  function automatic flavor_e pick_flavor();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return FlPmt;
    if (r < 45) return FlSdt;
    if (r < 55) return FlPat;
    if (r < 62) return FlOther;
    if (r < 72) return FlNull;
    return flavor_e'($urandom_range(FlNoSync, FlNoise));
  endfunction

  initial begin
    int unsigned packets;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = 1'b0;
    data_byte_i = 8'h00;
    packet_start_i = 1'b0;
    out_ready_i = 1'b0;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a report on empty counters, one packet of every kind
    // and every fault, a dropped fragment, then a report with real counts.
    send_stats();
    for (int f = FlPmt; f <= FlNoise; f++) begin
      build_packet(flavor_e'(f));
      send_packet(1'b1);
    end
    send_fragment();
    build_packet(FlPmt);
    send_packet(1'b1);
    send_stats();
    wait_drained();

    // Random part: mostly well-formed tables with random content, some noise.
    packets = 0;
    while (packets < 48) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (packets == 10) hold_request = 1;
      if (packets == 25) wait_drained();
      if ($urandom_range(0, 9) == 0) send_fragment();
      build_packet(pick_flavor());
      send_packet($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 7) == 0) send_stats();
      packets++;
    end
    send_stats();

    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== ts_psi_section_parser_core.f =====
src/tsp_pkg.sv
src/tsp_ram.sv
src/tsp_div.sv
src/tsp_front.sv
src/tsp_back.sv
src/ts_psi_section_parser_core.sv
sim/testbench.sv
